### rtl/rfis_pkg.sv
// Package for the radio frame identifier survey: types, codes, vendor OUI ROM.
// Used by rfis_parser and radio_frame_identifier_survey. No dependencies.
`default_nettype none
package rfis_pkg;
    localparam int TABLE_ENTRIES_DEF = 24;
    localparam int VENDOR_OUI_COUNT_DEF = 15;
    localparam int ROM_SIZE = 15;
    localparam logic [15:0] FIRST_ELEMENT = 16'd36;
    localparam logic [7:0] TAG_VENDOR = 8'hDD;
    localparam logic [7:0] TYPE_SERVICE16 = 8'h16;
    localparam logic [15:0] HIT_MAX = 16'hFFFF;
    localparam logic [15:0] POS_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_BEACON = 2'd0,
        FUNC_ADV    = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    localparam logic [1:0] KIND_VENDOR  = 2'd0;
    localparam logic [1:0] KIND_SERVICE = 2'd1;
    localparam logic [1:0] KIND_SENDER  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROM,
        ST_SEARCH,
        ST_BUMP,
        ST_READ,
        ST_OUT
    } state_t;

    // Request from the frame parser to the table sequencer. One byte can ask
    // for a sender OUI check and complete an element at the same time.
    typedef struct packed {
        logic        rom_check;
        logic        sender_note;
        logic [23:0] sender_id;
        logic        note;
        logic [1:0]  kind;
        logic [23:0] ident;
    } req_t;

    function automatic logic [23:0] vendor_rom(input logic [5:0] i);
        logic [23:0] r;
        unique case (i)
            6'd0:  r = 24'h04A85A;
            6'd1:  r = 24'h0C9AE6;
            6'd2:  r = 24'h201F55;
            6'd3:  r = 24'h3491F0;
            6'd4:  r = 24'h34D262;
            6'd5:  r = 24'h481CB9;
            6'd6:  r = 24'h4C43F6;
            6'd7:  r = 24'h58B858;
            6'd8:  r = 24'h60601F;
            6'd9:  r = 24'h882985;
            6'd10: r = 24'h8C5823;
            6'd11: r = 24'h9C5A8A;
            6'd12: r = 24'hE47A2C;
            6'd13: r = 24'hEC72F7;
            6'd14: r = 24'hF84068;
            default: r = 24'h0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/rfis_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rfis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/rfis_parser.sv
// Frame byte parser: position tracking, sender OUI capture, element/field walk.
// Depends on rfis_pkg; issues requests to the table sequencer.
`default_nettype none
module rfis_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          is_beacon,
    input  wire logic [7:0]    data_byte,
    input  wire logic          last_byte,
    input  wire logic          survey_enabled,
    output rfis_pkg::req_t     req
);
    logic [15:0] pos_reg, pos_next;
    logic [16:0] nhp_reg, nhp_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  tag_reg, tag_next;
    logic [23:0] cap_reg, cap_next;
    logic [23:0] oui_reg, oui_next;
    logic        stop_reg, stop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            nhp_reg  <= '0;
            len_reg  <= '0;
            tag_reg  <= '0;
            cap_reg  <= '0;
            oui_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            nhp_reg  <= nhp_next;
            len_reg  <= len_next;
            tag_reg  <= tag_next;
            cap_reg  <= cap_next;
            oui_reg  <= oui_next;
            stop_reg <= stop_next;
        end
    end

    always_comb
    begin
        logic [16:0] nh;
        logic [16:0] off;
        logic        live;
        pos_next  = pos_reg;
        nhp_next  = nhp_reg;
        len_next  = len_reg;
        tag_next  = tag_reg;
        cap_next  = cap_reg;
        oui_next  = oui_reg;
        stop_next = stop_reg;
        req       = '0;
        nh        = nhp_reg;
        off       = '0;
        live      = (pos_reg < rfis_pkg::POS_LIMIT);
        if (live)
        begin
            if (is_beacon)
            begin
                if (pos_reg == 16'd0)
                begin
                    nh = {1'b0, rfis_pkg::FIRST_ELEMENT};
                end
                nhp_next = nh;
                if (pos_reg >= 16'd10 && pos_reg <= 16'd12)
                begin
                    oui_next = {oui_reg[15:0], data_byte};
                end
                if (pos_reg == 16'd15)
                begin
                    req.rom_check   = 1'b1;
                    req.sender_note = survey_enabled;
                    req.sender_id   = oui_reg;
                end
                if ({1'b0, pos_reg} >= nh)
                begin
                    off = {1'b0, pos_reg} - nh;
                    if (off == 17'd0)
                    begin
                        tag_next = data_byte;
                        cap_next = '0;
                    end
                    else if (off == 17'd1)
                    begin
                        len_next = data_byte;
                    end
                    else if (off <= 17'd4)
                    begin
                        cap_next = {cap_reg[15:0], data_byte};
                    end
                    if (off >= 17'd1 && off == 17'd1 + {9'd0, len_next})
                    begin
                        if (tag_next == rfis_pkg::TAG_VENDOR && len_next >= 8'd4
                            && survey_enabled)
                        begin
                            req.note  = 1'b1;
                            req.kind  = rfis_pkg::KIND_VENDOR;
                            req.ident = cap_next;
                        end
                        nhp_next = {1'b0, pos_reg} + 17'd1;
                    end
                end
            end
            else if (!stop_reg && {1'b0, pos_reg} >= nhp_reg)
            begin
                off = {1'b0, pos_reg} - nhp_reg;
                if (off == 17'd0)
                begin
                    len_next = data_byte;
                    cap_next = '0;
                    if (data_byte == 8'd0)
                    begin
                        stop_next = 1'b1;
                    end
                end
                else
                begin
                    if (off == 17'd1)
                    begin
                        tag_next = data_byte;
                    end
                    else if (off <= 17'd3)
                    begin
                        cap_next = {8'd0, cap_reg[7:0], data_byte};
                    end
                    if (off == {9'd0, len_reg})
                    begin
                        if (len_reg >= 8'd3 && tag_next == rfis_pkg::TYPE_SERVICE16
                            && survey_enabled)
                        begin
                            req.note  = 1'b1;
                            req.kind  = rfis_pkg::KIND_SERVICE;
                            req.ident = {cap_next[15:0], 8'd0};
                        end
                        nhp_next = {1'b0, pos_reg} + 17'd1;
                    end
                end
            end
            pos_next = pos_reg + 16'd1;
        end
        if (last_byte)
        begin
            pos_next  = '0;
            nhp_next  = '0;
            stop_next = 1'b0;
        end
    end
endmodule
`default_nettype wire

### rtl/radio_frame_identifier_survey.sv
// Radio frame identifier survey, top level: handshake, sequencer, table RAMs.
// Depends on rfis_pkg, rfis_parser and rfis_ram.
//
// Usage: one input beat carries func, data_byte, last_byte and entry_index.
// Beacon (func 0) and advertisement (func 1) bytes are parsed in the cycle
// they are accepted, so bytes that complete nothing follow back to back.
// A sender OUI at beacon byte 15 is checked against the vendor ROM one entry
// per cycle, and each identifier that completes is looked up by a single
// shared comparator stepping through the table RAM. One byte can finish
// both a sender OUI and an element; the block then runs the ROM check and
// the lookups before it takes another item. A read (func 2) steps through
// ST_READ and ST_OUT and its output beat is registered; clear (func 3)
// gives none. Stall is high while an item is in work. The output beat is
// held in a register until the receiver lowers out_stall; other items are
// still taken meanwhile, and a further read waits until the held beat has
// gone. Reset empties the table, zeroes the vendor frame counter and frame
// walk, and clears survey_enabled; the table itself needs no clearing.
// Configuration writes on cfg_valid/cfg_ready are taken only while idle.
`default_nettype none
module radio_frame_identifier_survey #(
    parameter int TABLE_ENTRIES    = rfis_pkg::TABLE_ENTRIES_DEF,
    parameter int VENDOR_OUI_COUNT = rfis_pkg::VENDOR_OUI_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic [4:0]  entry_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             entry_valid,
    output logic [1:0]       entry_kind,
    output logic [23:0]      entry_id,
    output logic [15:0]      entry_count,
    output logic [4:0]       stored_entries,
    output logic [31:0]      vendor_frames,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int RW = $clog2(VENDOR_OUI_COUNT + 1);

    rfis_pkg::state_t state_reg, state_next;
    logic             survey_reg;
    logic [CW-1:0]    used_reg, used_next;
    logic [31:0]      vend_reg, vend_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [RW-1:0]    rom_reg, rom_next;
    rfis_pkg::req_t   req, req_reg, req_next;
    logic [1:0]       skind_reg, skind_next;
    logic [23:0]      sid_reg, sid_next;
    logic [4:0]       ridx_reg, ridx_next;
    logic             ovalid_reg, ovalid_next;
    logic             ev_reg, ev_next;
    logic [1:0]       ek_reg, ek_next;
    logic [23:0]      ei_reg, ei_next;
    logic [15:0]      ec_reg, ec_next;
    logic [4:0]       se_reg, se_next;
    logic [31:0]      vf_reg, vf_next;

    logic             accept, step, idle;
    logic             we;
    logic [AW-1:0]    addr;
    logic [41:0]      wdata, rdata;

    assign idle      = (state_reg == rfis_pkg::ST_IDLE);
    assign in_stall  = !idle;
    assign accept    = in_valid && idle;
    assign step      = accept && (func == rfis_pkg::FUNC_BEACON || func == rfis_pkg::FUNC_ADV);
    assign cfg_ready = idle;

    rfis_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .is_beacon      (func == rfis_pkg::FUNC_BEACON),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .survey_enabled (survey_reg),
        .req            (req)
    );

    // Kind, identifier and count stored in one word per entry.
    rfis_ram #(.WIDTH(42), .DEPTH(TABLE_ENTRIES)) u_table (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rfis_pkg::ST_IDLE;
            survey_reg <= 1'b0;
            used_reg   <= '0;
            vend_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            vend_reg   <= vend_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                survey_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        rom_reg   <= rom_next;
        req_reg   <= req_next;
        skind_reg <= skind_next;
        sid_reg   <= sid_next;
        ridx_reg  <= ridx_next;
        ev_reg    <= ev_next;
        ek_reg    <= ek_next;
        ei_reg    <= ei_next;
        ec_reg    <= ec_next;
        se_reg    <= se_next;
        vf_reg    <= vf_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        vend_next   = vend_reg;
        idx_next    = idx_reg;
        rom_next    = rom_reg;
        req_next    = req_reg;
        skind_next  = skind_reg;
        sid_next    = sid_reg;
        ridx_next   = ridx_reg;
        ovalid_next = ovalid_reg;
        ev_next     = ev_reg;
        ek_next     = ek_reg;
        ei_next     = ei_reg;
        ec_next     = ec_reg;
        se_next     = se_reg;
        vf_next     = vf_reg;
        we          = 1'b0;
        addr        = idx_reg[AW-1:0];
        wdata       = {skind_reg, sid_reg, 16'd1};
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            rfis_pkg::ST_IDLE:
            begin
                idx_next = '0;
                rom_next = '0;
                if (accept)
                begin
                    unique case (rfis_pkg::func_t'(func))
                        rfis_pkg::FUNC_BEACON, rfis_pkg::FUNC_ADV:
                        begin
                            req_next = req;
                            if (req.rom_check)
                            begin
                                state_next = rfis_pkg::ST_ROM;
                            end
                            else if (req.note)
                            begin
                                skind_next    = req.kind;
                                sid_next      = req.ident;
                                req_next.note = 1'b0;
                                state_next    = rfis_pkg::ST_SEARCH;
                            end
                        end
                        rfis_pkg::FUNC_CLEAR:
                        begin
                            used_next = '0;
                            vend_next = '0;
                        end
                        rfis_pkg::FUNC_READ:
                        begin
                            ridx_next  = entry_index;
                            state_next = rfis_pkg::ST_READ;
                        end
                    endcase
                end
            end
            rfis_pkg::ST_ROM:
            begin
                // One ROM entry compared per cycle. A matching sender OUI is
                // recorded before an element completed by the same byte.
                if (rom_reg == RW'(VENDOR_OUI_COUNT))
                begin
                    if (req_reg.note)
                    begin
                        skind_next    = req_reg.kind;
                        sid_next      = req_reg.ident;
                        req_next.note = 1'b0;
                        state_next    = rfis_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = rfis_pkg::ST_IDLE;
                    end
                end
                else if (rfis_pkg::vendor_rom(6'(rom_reg)) == req_reg.sender_id
                         && 32'(rom_reg) < 32'(rfis_pkg::ROM_SIZE))
                begin
                    vend_next = vend_reg + 32'd1;
                    if (req_reg.sender_note)
                    begin
                        skind_next = rfis_pkg::KIND_SENDER;
                        sid_next   = req_reg.sender_id;
                        state_next = rfis_pkg::ST_SEARCH;
                    end
                    else if (req_reg.note)
                    begin
                        skind_next    = req_reg.kind;
                        sid_next      = req_reg.ident;
                        req_next.note = 1'b0;
                        state_next    = rfis_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = rfis_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    rom_next = rom_reg + RW'(1);
                end
            end
            rfis_pkg::ST_SEARCH:
            begin
                // Issue read of entry idx_reg, compare arrives in ST_BUMP; past the last entry, append if room.
                if (idx_reg >= used_reg)
                begin
                    if (used_reg < CW'(TABLE_ENTRIES))
                    begin
                        we        = 1'b1;
                        used_next = used_reg + CW'(1);
                    end
                    if (req_reg.note)
                    begin
                        skind_next    = req_reg.kind;
                        sid_next      = req_reg.ident;
                        req_next.note = 1'b0;
                        idx_next      = '0;
                        state_next    = rfis_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = rfis_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = rfis_pkg::ST_BUMP;
                end
            end
            rfis_pkg::ST_BUMP:
            begin
                if (rdata[41:16] == {skind_reg, sid_reg})
                begin
                    if (rdata[15:0] != rfis_pkg::HIT_MAX)
                    begin
                        we    = 1'b1;
                        wdata = {rdata[41:16], rdata[15:0] + 16'd1};
                    end
                    if (req_reg.note)
                    begin
                        skind_next    = req_reg.kind;
                        sid_next      = req_reg.ident;
                        req_next.note = 1'b0;
                        idx_next      = '0;
                        state_next    = rfis_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = rfis_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = rfis_pkg::ST_SEARCH;
                end
            end
            rfis_pkg::ST_READ:
            begin
                addr       = AW'(ridx_reg);
                state_next = rfis_pkg::ST_OUT;
            end
            rfis_pkg::ST_OUT:
            begin
                // Keep the read address so the data survives a wait for the
                // previous beat to leave.
                addr = AW'(ridx_reg);
                if (!ovalid_reg || !out_stall)
                begin
                    ev_next     = (32'(ridx_reg) < 32'(used_reg));
                    ek_next     = ev_next ? rdata[41:40] : 2'd0;
                    ei_next     = ev_next ? rdata[39:16] : 24'd0;
                    ec_next     = ev_next ? rdata[15:0] : 16'd0;
                    se_next     = 5'(used_reg);
                    vf_next     = vend_reg;
                    ovalid_next = 1'b1;
                    state_next  = rfis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfis_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid      = ovalid_reg;
    assign entry_valid    = ev_reg;
    assign entry_kind     = ek_reg;
    assign entry_id       = ei_reg;
    assign entry_count    = ec_reg;
    assign stored_entries = se_reg;
    assign vendor_frames  = vf_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rfis_pkg::ST_IDLE) |-> in_stall)
        else $error("accepting while sequencer busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && out_stall) |=> (ovalid_reg && $stable(ei_reg)))
        else $error("stalled result changed");
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg) && used_reg != '0) |-> used_reg == $past(used_reg) + CW'(1))
        else $error("entry count jumped");
endmodule
`default_nettype wire

### dv/tb_radio_frame_identifier_survey.sv
// Self-checking testbench for the radio frame identifier survey block.
// Depends on rfis_pkg and radio_frame_identifier_survey; a scoreboard class predicts reads.
`timescale 1ns / 1ps
`default_nettype none

class survey_scoreboard;
    logic [1:0]  tab_kind [24];
    logic [23:0] tab_ident [24];
    logic [15:0] tab_hits [24];
    int unsigned used;
    logic [31:0] vendor_total;
    int unsigned pos;
    int unsigned hdr_pos;
    int unsigned el_len;
    logic [7:0]  el_tag;
    logic [23:0] cap_ident;
    logic [23:0] src_oui;
    bit          stopped;
    bit          enabled;
    logic [79:0] pending_reads [$];
    int          errors;

    function new();
        used = 0; vendor_total = 0; pos = 0; hdr_pos = 0; el_len = 0;
        el_tag = 0; cap_ident = 0; src_oui = 0; stopped = 0; enabled = 0; errors = 0;
    endfunction

    function bit is_vendor(logic [23:0] oui);
        logic [23:0] rom [15];
        rom = '{24'h04A85A, 24'h0C9AE6, 24'h201F55, 24'h3491F0, 24'h34D262,
                24'h481CB9, 24'h4C43F6, 24'h58B858, 24'h60601F, 24'h882985,
                24'h8C5823, 24'h9C5A8A, 24'hE47A2C, 24'hEC72F7, 24'hF84068};
        foreach (rom[i])
            if (rom[i] == oui)
                return 1;
        return 0;
    endfunction

    function void record_ident(logic [1:0] kind, logic [23:0] ident);
        for (int i = 0; i < used; i++)
        begin
            if (tab_kind[i] == kind && tab_ident[i] == ident)
            begin
                if (tab_hits[i] != 16'hFFFF)
                    tab_hits[i]++;
                return;
            end
        end
        if (used >= 24)
            return;
        tab_kind[used] = kind;
        tab_ident[used] = ident;
        tab_hits[used] = 1;
        used++;
    endfunction

    function void beacon_byte(logic [7:0] b);
        int unsigned off;
        if (pos == 0)
            hdr_pos = 36;
        if (pos >= 10 && pos <= 12)
            src_oui = {src_oui[15:0], b};
        if (pos == 15 && is_vendor(src_oui))
        begin
            vendor_total++;
            if (enabled)
                record_ident(rfis_pkg::KIND_SENDER, src_oui);
        end
        if (pos >= hdr_pos)
        begin
            off = pos - hdr_pos;
            if (off == 0)
            begin
                el_tag = b;
                cap_ident = 0;
            end
            else if (off == 1)
                el_len = b;
            else if (off <= 4)
                cap_ident = {cap_ident[15:0], b};
            if (off >= 1 && off == 1 + el_len)
            begin
                if (el_tag == rfis_pkg::TAG_VENDOR && el_len >= 4 && enabled)
                    record_ident(rfis_pkg::KIND_VENDOR, cap_ident);
                hdr_pos = pos + 1;
            end
        end
    endfunction

    function void adv_byte(logic [7:0] b);
        int unsigned off;
        if (stopped || pos < hdr_pos)
            return;
        off = pos - hdr_pos;
        if (off == 0)
        begin
            el_len = b;
            cap_ident = 0;
            if (b == 0)
                stopped = 1;
            return;
        end
        if (off == 1)
            el_tag = b;
        else if (off <= 3)
            cap_ident = {8'h00, cap_ident[7:0], b};
        if (off == el_len)
        begin
            if (el_len >= 3 && el_tag == rfis_pkg::TYPE_SERVICE16 && enabled)
                record_ident(rfis_pkg::KIND_SERVICE, {cap_ident[15:0], 8'h00});
            hdr_pos = pos + 1;
        end
    endfunction

    // Notes one accepted input beat and queues the read result it causes.
    function void note_input(rfis_pkg::func_t f, logic [7:0] b, logic last, logic [4:0] idx);
        if (f == rfis_pkg::FUNC_BEACON || f == rfis_pkg::FUNC_ADV)
        begin
            if (pos < 65535)
            begin
                if (f == rfis_pkg::FUNC_BEACON)
                    beacon_byte(b);
                else
                    adv_byte(b);
                pos++;
            end
            if (last)
            begin
                pos = 0;
                hdr_pos = 0;
                stopped = 0;
            end
        end
        else if (f == rfis_pkg::FUNC_CLEAR)
        begin
            used = 0;
            vendor_total = 0;
        end
        else if (idx < used)
            pending_reads.push_back({1'b1, tab_kind[idx], tab_ident[idx], tab_hits[idx],
                                     5'(used), vendor_total});
        else
            pending_reads.push_back({1'b0, 2'b0, 24'b0, 16'b0, 5'(used), vendor_total});
    endfunction

    function void check_read(logic [79:0] got);
        logic [79:0] want;
        if (pending_reads.size() == 0)
        begin
            $display("%0t: unexpected read beat, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_reads.pop_front();
        if (got[79] !== want[79])
            $display("%0t: entry_valid expected %h actual %h", $time, want[79], got[79]);
        if (got[78:77] !== want[78:77])
            $display("%0t: entry_kind expected %h actual %h", $time, want[78:77], got[78:77]);
        if (got[76:53] !== want[76:53])
            $display("%0t: entry_id expected %h actual %h", $time, want[76:53], got[76:53]);
        if (got[52:37] !== want[52:37])
            $display("%0t: entry_count expected %h actual %h", $time, want[52:37], got[52:37]);
        if (got[36:32] !== want[36:32])
            $display("%0t: stored_entries expected %h actual %h", $time, want[36:32],
                     got[36:32]);
        if (got[31:0] !== want[31:0])
            $display("%0t: vendor_frames expected %h actual %h", $time, want[31:0], got[31:0]);
        if (got !== want)
            errors++;
    endfunction
endclass

module tb_radio_frame_identifier_survey;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [4:0]  entry_index;
    logic        out_valid;
    logic        out_stall;
    logic        entry_valid;
    logic [1:0]  entry_kind;
    logic [23:0] entry_id;
    logic [15:0] entry_count;
    logic [4:0]  stored_entries;
    logic [31:0] vendor_frames;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    survey_scoreboard survey = new();
    int  cycles;
    bit  idle_free;
    bit  hold_out;
    int  reads_seen;

    radio_frame_identifier_survey i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .data_byte(data_byte), .last_byte(last_byte), .entry_index(entry_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .entry_valid(entry_valid), .entry_kind(entry_kind), .entry_id(entry_id),
        .entry_count(entry_count), .stored_entries(stored_entries),
        .vendor_frames(vendor_frames),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: random stalls, a long hold-off on request, checks each read beat.
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                survey.check_read({entry_valid, entry_kind, entry_id, entry_count,
                                   stored_entries, vendor_frames});
                reads_seen++;
            end
            if (hold_out)
            begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                hold_out = 0;
            end
            out_stall <= (!idle_free && $urandom_range(99) < 20);
        end
    end

    // The beat stays offered after acceptance until the next call replaces it
    // or idles, so in_valid is assigned once per time step.
    task automatic send_item(rfis_pkg::func_t f, logic [7:0] b, logic last, logic [4:0] idx);
        while (!idle_free && $urandom_range(99) < 20)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        func <= f;
        data_byte <= b;
        last_byte <= last;
        entry_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        survey.note_input(f, b, last, idx);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (survey.pending_reads.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_enable(bit en);
        drain();
        cfg_valid <= 1;
        cfg_data <= en;
        do
            @(posedge clk);
        while (!cfg_ready);
        survey.enabled = en;
        cfg_valid <= 0;
    endtask

    task automatic send_frame(rfis_pkg::func_t f, logic [7:0] bytes [$]);
        foreach (bytes[i])
            send_item(f, bytes[i], i == bytes.size() - 1, 5'($urandom));
    endtask

    function automatic void build_beacon(ref logic [7:0] q [$]);
        logic [23:0] oui;
        int n;
        q.delete();
        oui = ($urandom_range(3) != 0) ? 24'h3491F0 + 24'($urandom_range(0))
                                       : 24'($urandom_range(3));
        if ($urandom_range(1))
            oui = survey.is_vendor(24'hE47A2C) ? 24'hE47A2C : oui;
        for (int i = 0; i < 36; i++)
            q.push_back(8'($urandom));
        q[10] = oui[23:16]; q[11] = oui[15:8]; q[12] = oui[7:0];
        n = $urandom_range(3);
        for (int e = 0; e < n; e++)
        begin
            int len;
            len = $urandom_range(8);
            q.push_back($urandom_range(2) != 0 ? rfis_pkg::TAG_VENDOR : 8'($urandom));
            q.push_back(8'(len));
            for (int k = 0; k < len; k++)
                q.push_back(k < 3 ? 8'($urandom_range(3)) : 8'($urandom));
        end
        if ($urandom_range(9) == 0 && q.size() > 2)
            q.pop_back();
        if ($urandom_range(9) == 0)
            q = q[0:$urandom_range(20)];
    endfunction

    function automatic void build_adv(ref logic [7:0] q [$]);
        int n;
        q.delete();
        n = $urandom_range(1, 4);
        for (int e = 0; e < n; e++)
        begin
            int len;
            len = $urandom_range(12) == 0 ? 0 : $urandom_range(1, 6);
            q.push_back(8'(len));
            if (len > 0)
                q.push_back($urandom_range(2) != 0 ? rfis_pkg::TYPE_SERVICE16 : 8'($urandom));
            for (int k = 1; k < len; k++)
                q.push_back(k < 3 ? 8'($urandom_range(4)) : 8'($urandom));
        end
        if ($urandom_range(9) == 0 && q.size() > 1)
            q.pop_back();
    endfunction

    initial
    begin
        logic [7:0] frame [$];
        int r;
        rst_n = 0;
        in_valid = 0; func = rfis_pkg::FUNC_BEACON; data_byte = 0; last_byte = 0;
        entry_index = 0;
        cfg_valid = 0; cfg_data = 0; idle_free = 0; hold_out = 0; reads_seen = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty-table reads, vendor beacon with survey off and on, advert, clear.
        send_item(rfis_pkg::FUNC_READ, 0, 0, 0);
        send_item(rfis_pkg::FUNC_READ, 0, 0, 31);
        frame = {};
        for (int i = 0; i < 36; i++)
            frame.push_back(8'hFF);
        frame[10] = 8'hF8; frame[11] = 8'h40; frame[12] = 8'h68;
        frame.push_back(rfis_pkg::TAG_VENDOR); frame.push_back(8'd4);
        frame.push_back(8'h00); frame.push_back(8'hFF); frame.push_back(8'hAA);
        frame.push_back(8'h55);
        send_frame(rfis_pkg::FUNC_BEACON, frame);
        write_enable(1);
        send_frame(rfis_pkg::FUNC_BEACON, frame);
        frame = '{8'd3, rfis_pkg::TYPE_SERVICE16, 8'hFF, 8'h00, 8'd0, 8'h16};
        send_frame(rfis_pkg::FUNC_ADV, frame);
        for (int i = 0; i < 4; i++)
            send_item(rfis_pkg::FUNC_READ, 0, 0, 5'(i));
        send_item(rfis_pkg::FUNC_BEACON, 8'h01, 1, 0);
        send_item(rfis_pkg::FUNC_ADV, 8'h80, 0, 0);
        send_item(rfis_pkg::FUNC_BEACON, 8'h02, 1, 0);
        send_item(rfis_pkg::FUNC_CLEAR, 0, 0, 0);
        send_item(rfis_pkg::FUNC_READ, 0, 0, 0);

        // Random frames, reads and clears; survey is off in phase 3 only.
        for (int phase = 0; phase < 6; phase++)
        begin
            write_enable(phase != 3);
            idle_free = (phase == 2);
            if (phase == 1)
                hold_out = 1;
            for (int k = 0; k < 7; k++)
            begin
                r = $urandom_range(99);
                if (r < 40)
                begin
                    build_beacon(frame);
                    send_frame(rfis_pkg::FUNC_BEACON, frame);
                end
                else if (r < 75)
                begin
                    build_adv(frame);
                    send_frame(rfis_pkg::FUNC_ADV, frame);
                end
                else if (r < 78 && phase != 5)
                    send_item(rfis_pkg::FUNC_CLEAR, 0, 0, 0);
                else
                    send_item(rfis_pkg::FUNC_READ, 0, 0, 5'($urandom_range(31)));
                for (int j = 0; j < 3; j++)
                    send_item(rfis_pkg::FUNC_READ, 0, 0, 5'($urandom_range(25)));
                if (k == 6 && phase == 4)
                    drain();
            end
        end
        idle_free = 0;
        drain();
        if (survey.errors == 0 && survey.pending_reads.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire
